// ===== rtl/mqbf_pkg.sv =====
// Package with operation codes and field widths for the multi-queue byte FIFO.
`default_nettype none

package mqbf_pkg;

	localparam int FUNC_W = 3;
	localparam int QIDX_W = 3;
	localparam int BYTE_W = 8;

	typedef logic [FUNC_W-1:0] func_t;
	typedef logic [QIDX_W-1:0] qidx_t;
	typedef logic [BYTE_W-1:0] byte_t;

	localparam func_t OP_PUT     = 3'd0;
	localparam func_t OP_GET     = 3'd1;
	localparam func_t OP_CLEAR   = 3'd2;
	localparam func_t OP_PACK_LO = 3'd3;
	localparam func_t OP_PACK_HI = 3'd4;

	// Number of raw slots folded together by one pack operation.
	localparam int PACK_N = 8;

endpackage : mqbf_pkg

`default_nettype wire

// ===== rtl/multi_queue_byte_fifo_core.sv =====
// Top level of the multi-queue byte FIFO: a pool of circular byte queues in one row memory.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+------------------------------------
//  request   | req_valid, req_stall  | func, queue_index, item_in
//  result    | res_valid, res_stall  | data_out, ok, empty_now
//
// One request is accepted per cycle while req_stall is low; its result is registered
// as the request stage advances. The queue's row (slots, pointers, count) is read
// from the row memory at acceptance and written back as that stage advances;
// a back-to-back request to the same queue reads a forwarding register, not the memory.
// Reset marks every row invalid, and an invalid row reads as all zero.
// A stalled result holds the request stage; req_stall rises only when both are full.
`default_nettype none

module multi_queue_byte_fifo_core #(
	parameter int NUM_QUEUES  = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,

	input  wire                   req_valid,
	output logic                  req_stall,
	input  wire  mqbf_pkg::func_t func,
	input  wire  mqbf_pkg::qidx_t queue_index,
	input  wire  mqbf_pkg::byte_t item_in,

	output logic                  res_valid,
	input  wire                   res_stall,
	output logic [7:0]            data_out,
	output logic                  ok,
	output logic                  empty_now
);

	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = QUEUE_DEPTH * mqbf_pkg::BYTE_W;
	localparam int RW = SW + 2 * PW + CW;

	// Row layout, low to high: slots, write pointer, read pointer, fill count.
	localparam int WP_LO = SW;
	localparam int RP_LO = SW + PW;
	localparam int CN_LO = SW + 2 * PW;

	logic [RW-1:0]         row_mem [NUM_QUEUES];
	logic [NUM_QUEUES-1:0] row_valid_q;

	logic                  valid_s1;
	mqbf_pkg::func_t       func_s1;
	logic [QW-1:0]         qaddr_s1;
	logic                  inrange_s1;
	mqbf_pkg::byte_t       item_s1;
	logic [RW-1:0]         rd_row_s1;
	logic                  rd_valid_s1;
	logic                  fwd_s1;
	logic [RW-1:0]         fwd_row_s1;

	logic                  res_valid_q;
	logic [7:0]            data_out_q;
	logic                  ok_q;
	logic                  empty_now_q;

	logic                  req_acc;
	logic                  out_load;
	logic                  s1_adv;
	logic [QW-1:0]         req_addr;
	logic                  req_inrange;
	logic                  wr_en;

	logic [RW-1:0]         cur_row;
	mqbf_pkg::byte_t       slots     [QUEUE_DEPTH];
	mqbf_pkg::byte_t       new_slots [QUEUE_DEPTH];
	logic [PW-1:0]         wptr, rptr, new_wptr, new_rptr;
	logic [CW-1:0]         cnt, new_cnt;
	logic [RW-1:0]         new_row;
	logic [7:0]            res_data;
	logic                  res_ok;
	logic                  res_empty;
	logic [7:0]            pack_lo, pack_hi;

	assign out_load  = !res_valid_q || !res_stall;
	assign s1_adv    = valid_s1 && out_load;
	assign req_stall = valid_s1 && !out_load;
	assign req_acc   = req_valid && !req_stall;

	assign req_addr    = QW'(queue_index);
	assign req_inrange = (32'(queue_index) < NUM_QUEUES);

	// Request stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Request stage payload, the row read and the forwarding decision.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			func_s1     <= func;
			qaddr_s1    <= req_addr;
			inrange_s1  <= req_inrange;
			item_s1     <= item_in;
			rd_row_s1   <= row_mem[req_addr];
			rd_valid_s1 <= row_valid_q[req_addr];
			fwd_s1      <= wr_en && (qaddr_s1 == req_addr);
			fwd_row_s1  <= new_row;
		end
	end

	// Write-back of the modified row.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_mem[qaddr_s1] <= new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (wr_en) begin
			row_valid_q[qaddr_s1] <= 1'b1;
		end
	end

	always_comb begin
		if (fwd_s1) begin
			cur_row = fwd_row_s1;
		end else if (rd_valid_s1) begin
			cur_row = rd_row_s1;
		end else begin
			cur_row = '0;
		end
	end

	assign wptr = cur_row[WP_LO +: PW];
	assign rptr = cur_row[RP_LO +: PW];
	assign cnt  = cur_row[CN_LO +: CW];

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			slots[i] = cur_row[i*mqbf_pkg::BYTE_W +: mqbf_pkg::BYTE_W];
		end
	end

	// Packing is done in eight bits, since only the low byte of the sum is kept.
	always_comb begin
		pack_lo = '0;
		pack_hi = '0;
		for (int i = 0; i < mqbf_pkg::PACK_N; i++) begin
			pack_lo = pack_lo + 8'(slots[i] << i);
			pack_hi = pack_hi + 8'(slots[mqbf_pkg::PACK_N + i] << i);
		end
	end

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			new_slots[i] = slots[i];
		end
		new_wptr = wptr;
		new_rptr = rptr;
		new_cnt  = cnt;
		res_data = '0;
		res_ok   = 1'b0;
		wr_en    = 1'b0;
		case (func_s1)
			mqbf_pkg::OP_PUT: begin
				if (cnt < CW'(QUEUE_DEPTH)) begin
					new_slots[wptr] = item_s1;
					new_wptr = (wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr + PW'(1);
					new_cnt  = cnt + CW'(1);
					res_ok   = 1'b1;
					wr_en    = 1'b1;
				end
			end
			mqbf_pkg::OP_GET: begin
				if (cnt != '0) begin
					res_data = slots[rptr];
					new_rptr = (rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr + PW'(1);
					new_cnt  = cnt - CW'(1);
					res_ok   = 1'b1;
					wr_en    = 1'b1;
				end
			end
			mqbf_pkg::OP_CLEAR: begin
				for (int i = 0; i < QUEUE_DEPTH; i++) begin
					new_slots[i] = '0;
				end
				new_wptr = '0;
				new_rptr = '0;
				new_cnt  = '0;
				wr_en    = 1'b1;
			end
			mqbf_pkg::OP_PACK_LO: begin
				res_data = pack_lo;
			end
			mqbf_pkg::OP_PACK_HI: begin
				res_data = pack_hi;
			end
			default: begin
			end
		endcase
		// A queue index beyond the pool touches nothing.
		if (!inrange_s1) begin
			res_data = '0;
			res_ok   = 1'b0;
			wr_en    = 1'b0;
		end
		wr_en     = wr_en && s1_adv;
		res_empty = !inrange_s1 || (new_cnt == '0);
	end

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			new_row[i*mqbf_pkg::BYTE_W +: mqbf_pkg::BYTE_W] = new_slots[i];
		end
		new_row[WP_LO +: PW] = new_wptr;
		new_row[RP_LO +: PW] = new_rptr;
		new_row[CN_LO +: CW] = new_cnt;
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			data_out_q  <= res_data;
			ok_q        <= res_ok;
			empty_now_q <= res_empty;
		end
	end

	assign res_valid = res_valid_q;
	assign data_out  = data_out_q;
	assign ok        = ok_q;
	assign empty_now = empty_now_q;

endmodule : multi_queue_byte_fifo_core

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the multi-queue byte FIFO core with a request-level scoreboard.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_Q = 8;
	localparam int DEPTH = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 650;
	localparam int MAX_PRINTED = 100;

	// Function codes the block treats as no operation.
	localparam mqbf_pkg::func_t FUNC_UNUSED_LO = 3'd5;
	localparam mqbf_pkg::func_t FUNC_UNUSED_HI = 3'd7;

	typedef struct packed {
		mqbf_pkg::byte_t data;
		logic  ok;
		logic  empty;
	} fifo_result_t;

	typedef enum int {SEQ_FILL, SEQ_DRAIN, SEQ_MIXED, SEQ_NOISE} seq_kind_t;
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

	class fifo_pool_scoreboard;
		mqbf_pkg::byte_t slots [NUM_Q][DEPTH];
		logic [3:0]     wr_ptr [NUM_Q];
		logic [3:0]     rd_ptr [NUM_Q];
		logic [4:0]     fill [NUM_Q];
		fifo_result_t   expected_results [$];
		int             failures;
		int             printed;

		function new();
			for (int q = 0; q < NUM_Q; q++) begin
				for (int s = 0; s < DEPTH; s++) slots[q][s] = '0;
				wr_ptr[q] = '0;
				rd_ptr[q] = '0;
				fill[q] = '0;
			end
			failures = 0;
			printed = 0;
		endfunction

		function logic [3:0] next_slot(logic [3:0] p);
			return (p == DEPTH - 1) ? 4'd0 : p + 4'd1;
		endfunction

		function fifo_result_t predict_queue_op(mqbf_pkg::func_t f, mqbf_pkg::qidx_t q,
				mqbf_pkg::byte_t b);
			fifo_result_t r;
			int acc;
			int base;
			r = '0;
			acc = 0;
			base = 0;
			case (f)
			mqbf_pkg::OP_PUT: begin
				if (fill[q] < DEPTH) begin
					slots[q][wr_ptr[q]] = b;
					wr_ptr[q] = next_slot(wr_ptr[q]);
					fill[q] = fill[q] + 5'd1;
					r.ok = 1'b1;
				end
			end
			mqbf_pkg::OP_GET: begin
				if (fill[q] != 0) begin
					r.data = slots[q][rd_ptr[q]];
					rd_ptr[q] = next_slot(rd_ptr[q]);
					fill[q] = fill[q] - 5'd1;
					r.ok = 1'b1;
				end
			end
			mqbf_pkg::OP_CLEAR: begin
				for (int s = 0; s < DEPTH; s++) slots[q][s] = '0;
				wr_ptr[q] = '0;
				rd_ptr[q] = '0;
				fill[q] = '0;
			end
			mqbf_pkg::OP_PACK_LO, mqbf_pkg::OP_PACK_HI: begin
				// Raw slot positions are folded, not the FIFO order.
				base = (f == mqbf_pkg::OP_PACK_HI) ? 8 : 0;
				for (int i = 0; i < 8; i++) acc += int'(slots[q][base + i]) << i;
				r.data = acc[7:0];
			end
			default: begin
			end
			endcase
			r.empty = (fill[q] == 0);
			return r;
		endfunction

		function void note_request(mqbf_pkg::func_t f, mqbf_pkg::qidx_t q,
				mqbf_pkg::byte_t b);
			expected_results.push_back(predict_queue_op(f, q, b));
		endfunction

		function void report(string what, int exp_v, int act_v);
			failures++;
			if (printed < MAX_PRINTED) begin
				printed++;
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_v, act_v);
			end
		endfunction

		function void check_result(mqbf_pkg::byte_t got_data, logic got_ok, logic got_empty);
			fifo_result_t exp_r;
			if (expected_results.size() == 0) begin
				failures++;
				if (printed < MAX_PRINTED) begin
					printed++;
					$display("%0t: unexpected result: expected none, got data_out=%0d ok=%0d empty_now=%0d",
						$time, got_data, got_ok, got_empty);
				end
				return;
			end
			exp_r = expected_results.pop_front();
			if (got_data !== exp_r.data) report("data_out", exp_r.data, got_data);
			if (got_ok !== exp_r.ok) report("ok", exp_r.ok, got_ok);
			if (got_empty !== exp_r.empty) report("empty_now", exp_r.empty, got_empty);
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	mqbf_pkg::func_t func = mqbf_pkg::OP_PUT;
	mqbf_pkg::qidx_t queue_index = '0;
	mqbf_pkg::byte_t item_in = '0;
	logic  res_valid;
	logic  res_stall = 1'b0;
	logic [7:0] data_out;
	logic  ok;
	logic  empty_now;

	fifo_pool_scoreboard sb = new();
	int burst_left = 0;
	int cycles = 0;

	multi_queue_byte_fifo_core #(
		.NUM_QUEUES(NUM_Q),
		.QUEUE_DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.func(func),
		.queue_index(queue_index),
		.item_in(item_in),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.data_out(data_out),
		.ok(ok),
		.empty_now(empty_now)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, sb.pending());
			$display("** multi_queue_byte_fifo_core: FAILED **");
			$finish;
		end
	end

	// Values read here are the ones present just before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) sb.note_request(func, queue_index, item_in);
			if (res_valid && !res_stall) sb.check_result(data_out, ok, empty_now);
		end
	end

	initial begin : result_backpressure
		stall_mode_t mode;
		int run;
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			run = $urandom_range(4, 40);
			repeat (run) begin
				@(posedge clk);
				case (mode)
				STALL_NONE: res_stall <= 1'b0;
				STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
				default: res_stall <= ~res_stall;
				endcase
			end
		end
	end

	// Holds one request until it is taken; may open a gap when the current burst runs out.
	task automatic send_request(input mqbf_pkg::func_t f, input mqbf_pkg::qidx_t q,
			input mqbf_pkg::byte_t b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		req_valid <= 1'b1;
		func <= f;
		queue_index <= q;
		item_in <= b;
		do @(posedge clk); while (req_stall);
		burst_left--;
	endtask

	// The first negedge lets the monitor note the request taken at the last edge.
	task automatic wait_for_results();
		req_valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
		@(posedge clk);
		burst_left = 0;
	endtask

	function automatic mqbf_pkg::func_t pick_func(seq_kind_t kind);
		int roll;
		roll = $urandom_range(0, 99);
		case (kind)
		SEQ_FILL: begin
			if (roll < 85) return mqbf_pkg::OP_PUT;
		end
		SEQ_DRAIN: begin
			if (roll < 85) return mqbf_pkg::OP_GET;
		end
		SEQ_NOISE: return mqbf_pkg::func_t'($urandom_range(0, 7));
		default: begin
		end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < 40) return mqbf_pkg::OP_PUT;
		if (roll < 70) return mqbf_pkg::OP_GET;
		if (roll < 80) return mqbf_pkg::OP_PACK_LO;
		if (roll < 90) return mqbf_pkg::OP_PACK_HI;
		if (roll < 95) return mqbf_pkg::OP_CLEAR;
		return mqbf_pkg::func_t'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
	endfunction

	initial begin : stimulus
		int n_random;
		int len;
		bit drained_mid;
		seq_kind_t kind;
		mqbf_pkg::qidx_t q;
		n_random = 0;
		drained_mid = 0;
		do @(posedge clk); while (!arst_n);

		// Extreme bytes, get on an empty queue, packs, clear and the unused codes.
		send_request(mqbf_pkg::OP_PUT, 3'd0, 8'h00);
		send_request(mqbf_pkg::OP_PUT, 3'd0, 8'hFF);
		send_request(mqbf_pkg::OP_PACK_LO, 3'd0, 8'h00);
		send_request(mqbf_pkg::OP_PACK_HI, 3'd0, 8'h00);
		send_request(mqbf_pkg::OP_GET, 3'd0, 8'h00);
		send_request(mqbf_pkg::OP_GET, 3'd0, 8'h00);
		send_request(mqbf_pkg::OP_GET, 3'd0, 8'hFF);
		send_request(mqbf_pkg::OP_PUT, 3'd7, 8'h80);
		send_request(mqbf_pkg::OP_PUT, 3'd7, 8'h7F);
		send_request(mqbf_pkg::OP_PACK_LO, 3'd7, 8'h00);
		send_request(mqbf_pkg::OP_CLEAR, 3'd7, 8'h00);
		send_request(mqbf_pkg::OP_GET, 3'd7, 8'h00);
		send_request(mqbf_pkg::OP_PUT, 3'd3, 8'h55);
		for (int f = FUNC_UNUSED_LO; f <= FUNC_UNUSED_HI; f++)
			send_request(mqbf_pkg::func_t'(f), mqbf_pkg::qidx_t'(f - 4), 8'hAA);
		send_request(mqbf_pkg::OP_CLEAR, 3'd0, 8'h00);

		// Overfill one queue, then partly drain, refill and drain it fully so both pointers wrap.
		for (int i = 0; i < DEPTH + 1; i++)
			send_request(mqbf_pkg::OP_PUT, 3'd4, mqbf_pkg::byte_t'($urandom));
		send_request(mqbf_pkg::OP_PACK_HI, 3'd4, 8'h00);
		for (int i = 0; i < 5; i++) send_request(mqbf_pkg::OP_GET, 3'd4, 8'h00);
		for (int i = 0; i < 5; i++)
			send_request(mqbf_pkg::OP_PUT, 3'd4, mqbf_pkg::byte_t'($urandom));
		send_request(mqbf_pkg::OP_PACK_LO, 3'd4, 8'h00);
		for (int i = 0; i < DEPTH + 1; i++) send_request(mqbf_pkg::OP_GET, 3'd4, 8'h00);

		while (n_random < RANDOM_ITEMS) begin
			if (!drained_mid && n_random >= RANDOM_ITEMS / 2) begin
				wait_for_results();
				drained_mid = 1;
			end
			kind = seq_kind_t'($urandom_range(0, 3));
			len = (kind == SEQ_FILL || kind == SEQ_DRAIN) ? $urandom_range(6, 20)
				: $urandom_range(3, 16);
			q = mqbf_pkg::qidx_t'($urandom_range(0, NUM_Q - 1));
			for (int i = 0; i < len; i++) begin
				if (kind == SEQ_NOISE) q = mqbf_pkg::qidx_t'($urandom_range(0, NUM_Q - 1));
				send_request(pick_func(kind), q, mqbf_pkg::byte_t'($urandom));
				n_random++;
			end
		end

		wait_for_results();
		repeat (6) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("** multi_queue_byte_fifo_core: PASSED **");
		end else begin
			$display("** multi_queue_byte_fifo_core: FAILED **");
		end
		$finish;
	end

endmodule : tb_top

`default_nettype wire
